[design/wlld_pkg.sv]
// Shared types, constants and functions of the weighted least-load dispatcher.
package wlld_pkg;

    localparam int CNT_W   = 32;
    localparam int IDX_W   = 3;
    localparam int KINDS_W = 8;
    localparam int TPS_W   = 16;
    localparam int DUR_W   = 4;
    // duration * ticks_per_second, and that value times the largest weight
    localparam int BASE_W  = DUR_W + TPS_W;
    localparam int ADD_W   = BASE_W + 2;
    localparam int SUM_W   = CNT_W + 1;

    localparam logic [7:0] CHAR_M    = 8'h4D;
    localparam logic [7:0] CHAR_V    = 8'h56;
    localparam logic [7:0] CHAR_P    = 8'h50;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_ONE  = 8'h31;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic
    {
        CFG_SERVER_KINDS     = 1'b0,
        CFG_TICKS_PER_SECOND = 1'b1
    } cfg_index_t;

    typedef enum logic
    {
        ITEM_TICK    = 1'b0,
        ITEM_REQUEST = 1'b1
    } item_kind_t;

    typedef enum logic [1:0]
    {
        WEIGHT_ONE   = 2'd1,
        WEIGHT_TWO   = 2'd2,
        WEIGHT_THREE = 2'd3
    } weight_t;

    function automatic weight_t weight_of(input logic music, input logic [7:0] type_char);
        weight_t w;
        w = WEIGHT_ONE;
        if (!music)
        begin
            if (type_char == CHAR_M)
                w = WEIGHT_TWO;
        end
        else if (type_char == CHAR_V)
            w = WEIGHT_THREE;
        else if (type_char == CHAR_P)
            w = WEIGHT_TWO;
        return w;
    endfunction

    function automatic logic request_ok(input logic [7:0] type_char,
                                        input logic [7:0] duration_char);
        return (type_char == CHAR_M || type_char == CHAR_V || type_char == CHAR_P) &&
               duration_char >= CHAR_ONE && duration_char <= CHAR_NINE;
    endfunction

endpackage

[design/weighted_least_load_dispatcher_top.sv]
// Weighted least-load dispatcher: per-server load counters and least-total selection.
//
//  Channel  Direction  Ports                                   Contents
//  s_axis   in         s_axis_tvalid/tready/tdata/tuser        tick or dispatch request
//  m_axis   out        m_axis_tvalid/tready/tdata/tuser        dispatch result
//  cfg      in         cfg_valid/cfg_ready/cfg_index/cfg_data  register write
//
//  One item per cycle is sustained while no request waits on an untaken result; a request
//  result passes from the input register into the output register, where it is offered.
//  The input register feeds one pass of multiply, add and compare that updates the counters.
//  Ticks produce no result and never wait on the output side.
//  A request stalls in the input register only while the output register holds an untaken
//  result; reset clears all counters at once.
module weighted_least_load_dispatcher_top #(
    parameter int NUM_SERVERS = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,  // [7:0] type_char, [15:8] duration_char
    input  logic                          s_axis_tuser,  // [0] kind
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [39:0]                   m_axis_tdata,  // [2:0] server_index, [34:3] finish_ticks
    output logic                          m_axis_tuser,  // [0] accepted
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  wlld_pkg::cfg_index_t          cfg_index,
    input  logic [wlld_pkg::TPS_W-1:0]    cfg_data
);
    import wlld_pkg::*;

    logic [KINDS_W-1:0] server_kinds_reg;
    logic [TPS_W-1:0]   tps_reg;

    logic               in_valid_reg;
    item_kind_t         in_kind_reg;
    logic [7:0]         in_type_reg;
    logic [7:0]         in_dur_reg;

    logic [CNT_W-1:0]   work_reg  [NUM_SERVERS];
    logic [CNT_W-1:0]   work_next [NUM_SERVERS];

    logic               out_valid_reg;
    logic               out_accepted_reg;
    logic [IDX_W-1:0]   out_index_reg;
    logic [CNT_W-1:0]   out_ticks_reg;

    logic               out_free;
    logic               proc_fire;
    logic               req_ok;
    logic [DUR_W-1:0]   dur;
    logic [BASE_W-1:0]  base;
    logic [ADD_W-1:0]   add_x1;
    logic [ADD_W-1:0]   add_x2;
    logic [ADD_W-1:0]   add_x3;
    logic [SUM_W-1:0]   total [NUM_SERVERS];
    logic [SUM_W-1:0]   best;
    logic [IDX_W-1:0]   best_idx;
    logic [CNT_W-1:0]   best_sat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_kinds_reg <= KINDS_W'(4);
            tps_reg          <= TPS_W'(1000);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SERVER_KINDS:     server_kinds_reg <= cfg_data[KINDS_W-1:0];
                CFG_TICKS_PER_SECOND: tps_reg          <= cfg_data;
                default:              ;
            endcase
        end
    end

    // A tick always proceeds; a request needs room in the output register.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign proc_fire     = in_valid_reg && (in_kind_reg == ITEM_TICK || out_free);
    assign s_axis_tready = !in_valid_reg || proc_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_kind_reg <= item_kind_t'(s_axis_tuser);
            in_type_reg <= s_axis_tdata[7:0];
            in_dur_reg  <= s_axis_tdata[15:8];
        end
    end

    assign req_ok = request_ok(in_type_reg, in_dur_reg);
    assign dur    = DUR_W'(in_dur_reg - CHAR_ZERO);
    assign base   = BASE_W'(dur) * BASE_W'(tps_reg);
    assign add_x1 = ADD_W'(base);
    assign add_x2 = ADD_W'({base, 1'b0});
    assign add_x3 = add_x1 + add_x2;

    always_comb
    begin
        for (int i = 0; i < NUM_SERVERS; i++)
        begin
            case (weight_of(server_kinds_reg[i], in_type_reg))
                WEIGHT_TWO:   total[i] = SUM_W'(work_reg[i]) + SUM_W'(add_x2);
                WEIGHT_THREE: total[i] = SUM_W'(work_reg[i]) + SUM_W'(add_x3);
                default:      total[i] = SUM_W'(work_reg[i]) + SUM_W'(add_x1);
            endcase
        end
        best     = total[0];
        best_idx = '0;
        for (int i = 1; i < NUM_SERVERS; i++)
        begin
            if (total[i] < best)
            begin
                best     = total[i];
                best_idx = IDX_W'(i);
            end
        end
        best_sat = best[CNT_W] ? CNT_MAX : best[CNT_W-1:0];
    end

    always_comb
    begin
        for (int i = 0; i < NUM_SERVERS; i++)
        begin
            work_next[i] = work_reg[i];
            if (proc_fire)
            begin
                if (in_kind_reg == ITEM_TICK)
                begin
                    if (work_reg[i] != '0)
                        work_next[i] = work_reg[i] - CNT_W'(1);
                end
                else if (req_ok && best_idx == IDX_W'(i))
                    work_next[i] = best_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SERVERS; i++)
                work_reg[i] <= '0;
        end
        else
        begin
            for (int i = 0; i < NUM_SERVERS; i++)
                work_reg[i] <= work_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (proc_fire && in_kind_reg == ITEM_REQUEST)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && in_kind_reg == ITEM_REQUEST)
        begin
            out_accepted_reg <= req_ok;
            out_index_reg    <= req_ok ? best_idx : '0;
            out_ticks_reg    <= req_ok ? best_sat : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_accepted_reg;
    assign m_axis_tdata  = {5'b0, out_ticks_reg, out_index_reg};

endmodule

[design/wlld_checker.sv]
// Port-level assertions for the weighted least-load dispatcher, with its bind.
module wlld_checker #(
    parameter int NUM_SERVERS = 3
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    import wlld_pkg::*;

    // A result that is not taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn before its transfer");

    // A rejected request reports server zero and zero ticks.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 40'd0)
        else $error("rejected request carries a nonzero payload");

    // An accepted request names an existing server.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> 32'(m_axis_tdata[2:0]) < NUM_SERVERS)
        else $error("server index out of range");

    // A new result follows a request transfer through the input and output registers; a request that finds the
    // output register empty passes through the input register without waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready &&
                                       s_axis_tuser == ITEM_REQUEST, 2))
        else $error("result without a preceding request");

endmodule

bind weighted_least_load_dispatcher_top wlld_checker #(
    .NUM_SERVERS(NUM_SERVERS)
) u_wlld_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
